/* src/dndc_pkg.sv */
package dndc_pkg;

  // Register stages from input transfer to the output register, inclusive.
  localparam int unsigned PIPE_DEPTH = 7;

  localparam logic [13:0] YEAR_MAX = 14'd9999;
  localparam logic [22:0] DN_MIN   = 23'd1720724;
  localparam logic [22:0] DN_MAX   = 23'd5372782;

  // 32075 from the algorithm plus the 702 day offset of the day number.
  localparam logic [23:0] DN_BIAS  = 24'd32777;
  // 68569 from the algorithm plus the 702 day offset.
  localparam logic [22:0] L_BIAS   = 23'd69271;

  localparam logic CMD_TO_DN   = 1'b0;
  localparam logic CMD_TO_DATE = 1'b1;

  // Reciprocal constants: floor(x / d) == (x * K) >> S whenever x * d < 2**S.
  localparam int unsigned          DIV100_SH = 21;
  localparam logic [14:0]          DIV100_K  = 15'((64'd1 << DIV100_SH) / 64'd100 + 64'd1);
  localparam int unsigned          DIVN_SH   = 43;
  localparam logic [25:0]          DIVN_K    = 26'((64'd1 << DIVN_SH) / 64'd146097 + 64'd1);
  localparam int unsigned          DIVI_SH   = 49;
  localparam logic [28:0]          DIVI_K    = 29'((64'd1 << DIVI_SH) / 64'd1461001 + 64'd1);
  localparam int unsigned          DIVJ_SH   = 28;
  localparam logic [16:0]          DIVJ_K    = 17'((64'd1 << DIVJ_SH) / 64'd2447 + 64'd1);

  typedef struct packed {
    logic        cmd;
    logic [13:0] year_in;
    logic [3:0]  month_in;
    logic [4:0]  day_in;
    logic [22:0] day_number_in;
  } dndc_in_t;

  typedef struct packed {
    logic [22:0] day_number_out;
    logic [13:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic        valid_res;
  } dndc_out_t;

  // (367 * (m - 2 - 12 * a)) / 12, where a is -1 for January and February.
  function automatic logic [8:0] mon_offset(input logic [3:0] m);
    logic [8:0] r;
    unique case (m)
      4'd1:    r = 9'd336;
      4'd2:    r = 9'd367;
      4'd3:    r = 9'd30;
      4'd4:    r = 9'd61;
      4'd5:    r = 9'd91;
      4'd6:    r = 9'd122;
      4'd7:    r = 9'd152;
      4'd8:    r = 9'd183;
      4'd9:    r = 9'd214;
      4'd10:   r = 9'd244;
      4'd11:   r = 9'd275;
      4'd12:   r = 9'd305;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] r;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   r = 5'd30;
      4'd2:                                      r = leap ? 5'd29 : 5'd28;
      default:                                   r = 5'd0;
    endcase
    return r;
  endfunction

  // (2447 * j) / 80 for every 4-bit j.
  function automatic logic [8:0] j_offset(input logic [3:0] j);
    logic [8:0] r;
    unique case (j)
      4'd0:  r = 9'd0;
      4'd1:  r = 9'd30;
      4'd2:  r = 9'd61;
      4'd3:  r = 9'd91;
      4'd4:  r = 9'd122;
      4'd5:  r = 9'd152;
      4'd6:  r = 9'd183;
      4'd7:  r = 9'd214;
      4'd8:  r = 9'd244;
      4'd9:  r = 9'd275;
      4'd10: r = 9'd305;
      4'd11: r = 9'd336;
      4'd12: r = 9'd367;
      4'd13: r = 9'd397;
      4'd14: r = 9'd428;
      4'd15: r = 9'd458;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

/* src/dndc_date_lane.sv */
module dndc_date_lane import dndc_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [13:0] year,
  input  logic [3:0]  month,
  input  logic [4:0]  day,
  output logic [22:0] day_number,
  output logic        ok
);

  // Stage 1 registers.
  logic        ok1;
  logic [13:0] ys;
  logic [3:0]  ms;
  logic [4:0]  ds;
  logic [24:0] t1;
  logic [8:0]  t2;
  logic [28:0] prod_y;
  logic [28:0] prod_x3;

  logic        range_ok;
  logic [13:0] ys_next;
  logic [3:0]  ms_next;
  logic        feb;
  logic [14:0] ya;
  logic [13:0] x3;

  always_comb begin
    range_ok = (year != 14'd0) && (year <= YEAR_MAX) && (month >= 4'd1) &&
               (month <= 4'd12) && (day != 5'd0);
    // An out-of-range date is replaced by a harmless one so that every
    // intermediate stays inside its width; the result is zeroed later.
    ys_next  = range_ok ? year : 14'd1;
    ms_next  = range_ok ? month : 4'd1;
    feb      = (ms_next <= 4'd2);
    ya       = 15'(ys_next) + 15'd4800 - 15'(feb);
    x3       = 14'(15'(ys_next) + 15'd4900 - 15'(feb));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok1     <= range_ok;
      ys      <= ys_next;
      ms      <= ms_next;
      ds      <= day;
      t1      <= 25'(ya) * 25'd1461;
      t2      <= mon_offset(ms_next);
      prod_y  <= 29'(ys_next) * 29'(DIV100_K);
      prod_x3 <= 29'(x3) * 29'(DIV100_K);
    end
  end

  // Stage 2: leap year, month length and the final sum.
  logic [6:0]  q_y;
  logic [7:0]  q3;
  logic        century;
  logic        leap;
  logic [4:0]  lim;
  logic [8:0]  t3;
  logic [23:0] sum;
  logic        ok_next;

  always_comb begin
    q_y     = prod_y[DIV100_SH +: 7];
    q3      = prod_x3[DIV100_SH +: 8];
    century = (ys == 14'(q_y) * 14'd100);
    leap    = century ? (q_y[1:0] == 2'd0) : (ys[1:0] == 2'd0);
    lim     = month_len(ms, leap);
    t3      = 9'((10'(q3) * 10'd3) >> 2);
    sum     = 24'(t1[24:2]) + 24'(t2) + 24'(ds) - 24'(t3) - DN_BIAS;
    ok_next = ok1 && (ds <= lim);
  end

  // Stage 2 onward: the result rides a delay line to the output stage.
  logic [22:0] dn_dly [PIPE_DEPTH-1];
  logic        ok_dly [PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (en) begin
      dn_dly[0] <= ok_next ? sum[22:0] : 23'd0;
      ok_dly[0] <= ok_next;
      for (int k = 1; k < PIPE_DEPTH - 1; k++) begin
        dn_dly[k] <= dn_dly[k-1];
        ok_dly[k] <= ok_dly[k-1];
      end
    end
  end

  assign day_number = dn_dly[PIPE_DEPTH-2];
  assign ok         = ok_dly[PIPE_DEPTH-2];

endmodule

/* src/dndc_dn_lane.sv */
module dndc_dn_lane import dndc_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [22:0] day_number,
  output logic [13:0] year,
  output logic [3:0]  month,
  output logic [4:0]  day,
  output logic        ok
);

  // Stage 1: range check and the 400-year cycle product.
  logic        dn_ok;
  logic [22:0] l_next;
  logic        ok1;
  logic [22:0] l1;
  logic [50:0] prod_n;

  always_comb begin
    dn_ok  = (day_number >= DN_MIN) && (day_number <= DN_MAX);
    l_next = (dn_ok ? day_number : DN_MIN) + L_BIAS;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok1    <= dn_ok;
      l1     <= l_next;
      prod_n <= 51'({l_next, 2'b00}) * 51'(DIVN_K);
    end
  end

  // Stage 2: day within the 400-year cycle.
  logic [7:0]  n_next;
  logic [15:0] l2_next;
  logic        ok2;
  logic [7:0]  n2;
  logic [15:0] l2;

  always_comb begin
    n_next  = prod_n[DIVN_SH +: 8];
    l2_next = 16'(l1 - 23'((26'(n_next) * 26'd146097 + 26'd3) >> 2));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok2 <= ok1;
      n2  <= n_next;
      l2  <= l2_next;
    end
  end

  // Stage 3: numerator of the year-in-cycle quotient.
  logic        ok3;
  logic [7:0]  n3;
  logic [15:0] l2_3;
  logic [27:0] num_i;

  always_ff @(posedge clk) begin
    if (en) begin
      ok3   <= ok2;
      n3    <= n2;
      l2_3  <= l2;
      num_i <= 28'(17'(l2) + 17'd1) * 28'd4000;
    end
  end

  // Stage 4: reciprocal product for the division by 1461001.
  logic        ok4;
  logic [7:0]  n4;
  logic [15:0] l2_4;
  logic [56:0] prod_i;

  always_ff @(posedge clk) begin
    if (en) begin
      ok4    <= ok3;
      n4     <= n3;
      l2_4   <= l2_3;
      prod_i <= 57'(num_i) * 57'(DIVI_K);
    end
  end

  // Stage 5: year in cycle and day of the shifted year.
  logic [6:0]  i_next;
  logic [8:0]  l3_next;
  logic        ok5;
  logic [7:0]  n5;
  logic [6:0]  i5;
  logic [8:0]  l3;

  always_comb begin
    i_next  = prod_i[DIVI_SH +: 7];
    l3_next = 9'(17'(l2_4) - 17'((18'(i_next) * 18'd1461) >> 2) + 17'd31);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok5 <= ok4;
      n5  <= n4;
      i5  <= i_next;
      l3  <= l3_next;
    end
  end

  // Stage 6: reciprocal product for the division by 2447.
  logic        ok6;
  logic [7:0]  n6;
  logic [6:0]  i6;
  logic [8:0]  l3_6;
  logic [32:0] prod_j;

  always_ff @(posedge clk) begin
    if (en) begin
      ok6    <= ok5;
      n6     <= n5;
      i6     <= i5;
      l3_6   <= l3;
      prod_j <= 33'(16'(l3) * 16'd80) * 33'(DIVJ_K);
    end
  end

  // Stage 7: assemble the date; invalid day numbers give all zeros.
  logic [3:0]  j;
  logic        past_dec;
  logic [3:0]  month_next;
  logic [4:0]  day_next;
  logic [13:0] year_next;

  always_comb begin
    j          = prod_j[DIVJ_SH +: 4];
    // j runs from March (1) through February of the next year (12).
    past_dec   = (j >= 4'd11);
    month_next = past_dec ? 4'(j - 4'd10) : 4'(j + 4'd2);
    day_next   = 5'(l3_6 - j_offset(j));
    year_next  = (14'(n6) - 14'd49) * 14'd100 + 14'(i6) + 14'(past_dec);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok    <= ok6;
      year  <= ok6 ? year_next : 14'd0;
      month <= ok6 ? month_next : 4'd0;
      day   <= ok6 ? day_next : 5'd0;
    end
  end

endmodule

/* src/day_number_date_converter.sv */
// Gregorian date <-> day number converter (Julian day minus 702).
//
// Input channel in_valid/in_ready/in_data carries one request per transfer.
// With cmd at zero the year, month and day fields are checked and turned
// into a day number; with cmd at one day_number_in is turned into a date.
// Output channel out_valid/out_ready/out_data returns exactly one result per
// request, in order. valid_res is low for a date that does not exist or a
// day number outside 0001-01-01 .. 9999-12-31, and then every numeric field
// is zero; fields that belong to the other direction are always zero.
//
// The pipeline depth is set by the chain of constant reciprocal multiplies
// in the day-number-to-date path. A new request is taken every cycle as long
// as the output stage is empty or its result is taken.
// When the receiver holds out_ready low with a result waiting, the whole
// pipeline freezes and in_ready drops; nothing is lost or repeated.
// Reset (rst, synchronous) empties the pipeline; there is no other state.
module day_number_date_converter import dndc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  dndc_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output dndc_out_t out_data
);

  logic [PIPE_DEPTH-1:0] vld;
  logic [PIPE_DEPTH-1:0] cmd_pipe;
  logic                  adv;

  assign adv      = !vld[PIPE_DEPTH-1] || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[PIPE_DEPTH-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd_pipe <= {cmd_pipe[PIPE_DEPTH-2:0], in_data.cmd};
    end
  end

  logic [22:0] date_dn;
  logic        date_ok;
  logic [13:0] dn_year;
  logic [3:0]  dn_month;
  logic [4:0]  dn_day;
  logic        dn_ok;

  dndc_date_lane u_date_lane (
    .clk        (clk),
    .en         (adv),
    .year       (in_data.year_in),
    .month      (in_data.month_in),
    .day        (in_data.day_in),
    .day_number (date_dn),
    .ok         (date_ok)
  );

  dndc_dn_lane u_dn_lane (
    .clk        (clk),
    .en         (adv),
    .day_number (in_data.day_number_in),
    .year       (dn_year),
    .month      (dn_month),
    .day        (dn_day),
    .ok         (dn_ok)
  );

  always_comb begin
    if (cmd_pipe[PIPE_DEPTH-1] == CMD_TO_DN) begin
      out_data.day_number_out = date_dn;
      out_data.year_out       = 14'd0;
      out_data.month_out      = 4'd0;
      out_data.day_out        = 5'd0;
      out_data.valid_res      = date_ok;
    end else begin
      out_data.day_number_out = 23'd0;
      out_data.year_out       = dn_year;
      out_data.month_out      = dn_month;
      out_data.day_out        = dn_day;
      out_data.valid_res      = dn_ok;
    end
  end

  assign out_valid = vld[PIPE_DEPTH-1];

  // A rejected request carries no numbers.
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.valid_res |->
      out_data.day_number_out == 23'd0 && out_data.year_out == 14'd0 &&
      out_data.month_out == 4'd0 && out_data.day_out == 5'd0)
    else $error("rejected request returned nonzero fields");

  a_date_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.valid_res && cmd_pipe[PIPE_DEPTH-1] == CMD_TO_DATE |->
      out_data.month_out >= 4'd1 && out_data.month_out <= 4'd12 &&
      out_data.day_out >= 5'd1 && out_data.day_out <= 5'd31 &&
      out_data.year_out >= 14'd1 && out_data.year_out <= YEAR_MAX)
    else $error("converted date out of range");

  a_dn_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.valid_res && cmd_pipe[PIPE_DEPTH-1] == CMD_TO_DN |->
      out_data.day_number_out >= DN_MIN && out_data.day_number_out <= DN_MAX)
    else $error("converted day number out of range");

endmodule

/* sim/day_number_date_converter_test.sv */
`timescale 1ns / 100ps

module day_number_date_converter_test import dndc_pkg::*; ();

  localparam int RANDOM_ITEMS = 1930;
  localparam int CYCLE_LIMIT  = 500000;

  localparam dndc_out_t REJECTED = '0;

  typedef struct packed {
    dndc_in_t  stim;
    logic      fixed;
    dndc_out_t want;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  dndc_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  dndc_out_t out_data;

  // Expectation attached to the request currently on the input channel.
  logic      row_fixed;
  dndc_out_t row_want;

  dir_row_t  dir_rows[$];
  dndc_out_t pending_conversions[$];
  int        fail_count = 0;
  int        cycle_count = 0;
  logic [15:0] stall_pat = '0;
  int        stall_pos = 0;

  day_number_date_converter DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  function automatic bit leap_year(input longint y);
    if (y % 400 == 0) return 1'b1;
    if (y % 100 == 0) return 1'b0;
    return y % 4 == 0;
  endfunction

  function automatic longint max_day(input longint y, input longint m);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return leap_year(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  function automatic dndc_out_t convert_request(input dndc_in_t req);
    dndc_out_t res;
    longint y, m, d, a, dn, l, n, i, j;
    res = REJECTED;
    if (req.cmd == CMD_TO_DN) begin
      y = req.year_in;
      m = req.month_in;
      d = req.day_in;
      if (y >= 1 && y <= YEAR_MAX && d >= 1 && d <= max_day(y, m)) begin
        // The month term is negative for January and February; division truncates.
        a = (m - 14) / 12;
        dn = (1461 * (y + 4800 + a)) / 4 + (367 * (m - 2 - 12 * a)) / 12
             - (3 * ((y + 4900 + a) / 100)) / 4 + d - 32075 - 702;
        res.day_number_out = 23'(dn);
        res.valid_res = 1'b1;
      end
    end else begin
      dn = req.day_number_in;
      if (dn >= DN_MIN && dn <= DN_MAX) begin
        l = dn + 702 + 68569;
        n = (4 * l) / 146097;
        l = l - (146097 * n + 3) / 4;
        i = (4000 * (l + 1)) / 1461001;
        l = l - (1461 * i) / 4 + 31;
        j = (80 * l) / 2447;
        d = l - (2447 * j) / 80;
        l = j / 11;
        m = j + 2 - 12 * l;
        y = 100 * (n - 49) + i + l;
        if (max_day(y, m) > 0 && d >= 1 && d <= max_day(y, m)) begin
          res.year_out  = 14'(y);
          res.month_out = 4'(m);
          res.day_out   = 5'(d);
          res.valid_res = 1'b1;
        end
      end
    end
    return res;
  endfunction

  // Mostly well-formed dates and in-range day numbers, some raw noise.
  function automatic dndc_in_t random_request();
    dndc_in_t req;
    int unsigned pick;
    longint y, m, lim;
    req.cmd           = 1'($urandom);
    req.year_in       = 14'($urandom);
    req.month_in      = 4'($urandom);
    req.day_in        = 5'($urandom);
    req.day_number_in = 23'($urandom);
    pick = $urandom_range(0, 9);
    if (pick <= 3) begin
      req.cmd = CMD_TO_DN;
      y = $urandom_range(1, YEAR_MAX);
      m = $urandom_range(1, 12);
      lim = max_day(y, m);
      req.year_in  = 14'(y);
      req.month_in = 4'(m);
      case ($urandom_range(0, 3))
        0:       req.day_in = 5'(lim);
        1:       req.day_in = (lim < 31) ? 5'(lim + 1) : 5'd0;
        default: req.day_in = 5'($urandom_range(1, 32'(lim)));
      endcase
    end else if (pick <= 7) begin
      req.cmd = CMD_TO_DATE;
      req.day_number_in = 23'($urandom_range(DN_MIN, DN_MAX));
    end else if (pick == 8) begin
      req.cmd = CMD_TO_DN;
    end else begin
      req.cmd = CMD_TO_DATE;
    end
    return req;
  endfunction

  task automatic add_row(input dndc_in_t stim, input logic fixed, input dndc_out_t want);
    dir_rows.insert(dir_rows.size(), dir_row_t'{stim, fixed, want});
  endtask

  initial begin
    dir_row_t row;
    int burst_left;
    int gap;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    row_fixed = 1'b0;
    row_want  = '0;

    // Range ends in both directions.
    add_row(dndc_in_t'{CMD_TO_DN, 14'd1, 4'd1, 5'd1, 23'd0}, 1'b1,
            dndc_out_t'{23'd1720724, 14'd0, 4'd0, 5'd0, 1'b1});
    add_row(dndc_in_t'{CMD_TO_DN, 14'd9999, 4'd12, 5'd31, 23'h7FFFFF}, 1'b1,
            dndc_out_t'{23'd5372782, 14'd0, 4'd0, 5'd0, 1'b1});
    add_row(dndc_in_t'{CMD_TO_DATE, 14'h3FFF, 4'hF, 5'h1F, 23'd1720724}, 1'b1,
            dndc_out_t'{23'd0, 14'd1, 4'd1, 5'd1, 1'b1});
    add_row(dndc_in_t'{CMD_TO_DATE, 14'd0, 4'd0, 5'd0, 23'd5372782}, 1'b1,
            dndc_out_t'{23'd0, 14'd9999, 4'd12, 5'd31, 1'b1});
    // Day numbers just outside the range, and the field extremes.
    add_row(dndc_in_t'{CMD_TO_DATE, 14'd0, 4'd0, 5'd0, 23'd1720723}, 1'b1, REJECTED);
    add_row(dndc_in_t'{CMD_TO_DATE, 14'd0, 4'd0, 5'd0, 23'd5372783}, 1'b1, REJECTED);
    add_row(dndc_in_t'{CMD_TO_DATE, 14'd2000, 4'd1, 5'd1, 23'd0}, 1'b1, REJECTED);
    add_row(dndc_in_t'{CMD_TO_DATE, 14'h3FFF, 4'hF, 5'h1F, 23'h7FFFFF}, 1'b1, REJECTED);
    // Dates that do not exist.
    add_row(dndc_in_t'{CMD_TO_DN, 14'd0, 4'd1, 5'd1, 23'd0}, 1'b1, REJECTED);
    add_row(dndc_in_t'{CMD_TO_DN, 14'd10000, 4'd12, 5'd31, 23'd0}, 1'b1, REJECTED);
    add_row(dndc_in_t'{CMD_TO_DN, 14'h3FFF, 4'hF, 5'h1F, 23'h7FFFFF}, 1'b1, REJECTED);
    add_row(dndc_in_t'{CMD_TO_DN, 14'd2020, 4'd0, 5'd10, 23'd0}, 1'b1, REJECTED);
    add_row(dndc_in_t'{CMD_TO_DN, 14'd2020, 4'd13, 5'd10, 23'd0}, 1'b1, REJECTED);
    add_row(dndc_in_t'{CMD_TO_DN, 14'd2020, 4'd6, 5'd0, 23'd0}, 1'b1, REJECTED);
    add_row(dndc_in_t'{CMD_TO_DN, 14'd2021, 4'd4, 5'd31, 23'd0}, 1'b1, REJECTED);
    add_row(dndc_in_t'{CMD_TO_DN, 14'd1900, 4'd2, 5'd29, 23'd0}, 1'b1, REJECTED);
    add_row(dndc_in_t'{CMD_TO_DN, 14'd2100, 4'd2, 5'd29, 23'd0}, 1'b1, REJECTED);
    add_row(dndc_in_t'{CMD_TO_DN, 14'd2023, 4'd2, 5'd29, 23'd0}, 1'b1, REJECTED);
    // Leap days, ordinary dates and day numbers go through the predictor.
    add_row(dndc_in_t'{CMD_TO_DN, 14'd2000, 4'd2, 5'd29, 23'd0}, 1'b0, REJECTED);
    add_row(dndc_in_t'{CMD_TO_DN, 14'd2024, 4'd2, 5'd29, 23'd0}, 1'b0, REJECTED);
    add_row(dndc_in_t'{CMD_TO_DN, 14'd2024, 4'd1, 5'd31, 23'h7FFFFF}, 1'b0, REJECTED);
    add_row(dndc_in_t'{CMD_TO_DN, 14'd1970, 4'd1, 5'd1, 23'h2AAAAA}, 1'b0, REJECTED);
    add_row(dndc_in_t'{CMD_TO_DATE, 14'd0, 4'd0, 5'd0, 23'd2459299}, 1'b0, REJECTED);
    add_row(dndc_in_t'{CMD_TO_DATE, 14'd0, 4'd0, 5'd0, 23'd2451604}, 1'b0, REJECTED);

    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    burst_left = 0;
    for (int k = 0; k < dir_rows.size() + RANDOM_ITEMS; k++) begin
      if (k < dir_rows.size()) begin
        row = dir_rows[k];
      end else begin
        row.stim  = random_request();
        row.fixed = 1'b0;
        row.want  = REJECTED;
      end
      if (burst_left == 0) begin
        gap = $urandom_range(0, 6);
        burst_left = $urandom_range(1, 24);
        if (gap != 0) begin
          @(negedge clk) in_valid <= 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
      end
      burst_left--;
      @(negedge clk);
      in_valid  <= 1'b1;
      in_data   <= row.stim;
      row_fixed <= row.fixed;
      row_want  <= row.want;
      do @(posedge clk); while (!(in_valid && in_ready));
    end
    @(negedge clk) in_valid <= 1'b0;

    while (pending_conversions.size() != 0) @(posedge clk);
    // Any extra result would show up within a few pipeline lengths.
    repeat (4 * PIPE_DEPTH) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // The receiver stalls on a 16-bit pattern that is redrawn every lap.
  always @(negedge clk) begin
    if (stall_pos == 0) begin
      case ($urandom_range(0, 2))
        0:       stall_pat = '0;
        1:       stall_pat = 16'($urandom);
        default: stall_pat = 16'($urandom | $urandom);
      endcase
    end
    out_ready <= !stall_pat[stall_pos];
    stall_pos = (stall_pos + 1) % 16;
  end

  always @(posedge clk) begin : result_check
    dndc_out_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        pending_conversions.insert(pending_conversions.size(),
                                   row_fixed ? row_want : convert_request(in_data));
      end
      if (out_valid && out_ready) begin
        if (pending_conversions.size() == 0) begin
          if (fail_count < 10) begin
            $display("unexpected transfer: dn=%0d y=%0d m=%0d d=%0d v=%0b",
                     out_data.day_number_out, out_data.year_out, out_data.month_out,
                     out_data.day_out, out_data.valid_res);
          end
          fail_count++;
        end else begin
          want = pending_conversions.pop_front();
          if (out_data.day_number_out !== want.day_number_out ||
              out_data.year_out !== want.year_out ||
              out_data.month_out !== want.month_out ||
              out_data.day_out !== want.day_out ||
              out_data.valid_res !== want.valid_res) begin
            if (fail_count < 10) begin
              $display("mismatch: expected dn=%0d y=%0d m=%0d d=%0d v=%0b, got dn=%0d y=%0d m=%0d d=%0d v=%0b",
                       want.day_number_out, want.year_out, want.month_out, want.day_out,
                       want.valid_res, out_data.day_number_out, out_data.year_out,
                       out_data.month_out, out_data.day_out, out_data.valid_res);
            end
            fail_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule
